// ===== src/csc_pkg.sv =====
// csc_pkg: widths, Q2.30 constants, arctangent table and pipeline control type
// for the CORDIC sine/cosine unit. No dependencies.
package csc_pkg;

  // Port widths
  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 32;

  // Internal widths: unsigned reduced angle, signed residual angle, signed x/y
  localparam int A_W  = 34;
  localparam int Z_W  = 32;
  localparam int XY_W = 34;

  localparam int TAB_LEN = 32;

  // Q2.30 constants
  localparam logic [A_W-1:0] TWO_PI_Q30  = 34'h1_921F_B544;
  localparam logic [A_W-1:0] PI_Q30      = 34'h0_C90F_DAA2;
  localparam logic [A_W-1:0] HALF_PI_Q30 = 34'h0_6487_ED51;
  localparam logic signed [XY_W-1:0] GAIN_K_Q30 = 34'sh0_26DD_3B6A;

  // Saturation bounds on the widened result
  localparam logic signed [XY_W:0] SAT_POS = 35'sh0_4000_0000;
  localparam logic signed [XY_W:0] SAT_NEG = -35'sh0_4000_0000;

  // atan(2^-k) in Q2.30
  localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
    32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
    32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
    32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
    32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F,
    32'sh0000003F, 32'sh0000001F, 32'sh0000000F, 32'sh00000008,
    32'sh00000004, 32'sh00000002, 32'sh00000001, 32'sh00000000
  };

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;

  // Control that travels down the pipeline with each request
  typedef struct packed {
    logic valid;  // stage holds a request
    logic neg;    // input angle was negative
    logic flip;   // one pi was removed
    logic swap;   // second quadrant: sine/cosine swapped
  } csc_ctl_t;

endpackage

// ===== src/csc_cordic_stage.sv =====
// csc_cordic_stage: one registered rotation-mode CORDIC iteration.
// Depends on csc_pkg for the data types and the arctangent table.
module csc_cordic_stage
  import csc_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  csc_ctl_t ctl_i,
  input  xy_t      x_i,
  input  xy_t      y_i,
  input  z_t       z_i,
  output csc_ctl_t ctl_o,
  output xy_t      x_o,
  output xy_t      y_o,
  output z_t       z_o
);

  csc_ctl_t ctl_r;
  xy_t      x_r, y_r, x_nxt, y_nxt;
  z_t       z_r, z_nxt;
  xy_t      dx, dy;
  z_t       atan_k;

  // Shifted cross terms (arithmetic shift, floor) and the angle step
  assign dx     = y_i >>> SHIFT;
  assign dy     = x_i >>> SHIFT;
  assign atan_k = ATAN_TAB[SHIFT];

  // Rotate toward zero residual angle
  always_comb begin
    if (z_i[Z_W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + atan_k;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - atan_k;
    end
  end

  // Control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // Data registers
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

// ===== src/cordic_sine_cosine_unit.sv =====
// cordic_sine_cosine_unit: pipelined CORDIC sine/cosine of a Q3.28 angle (uses csc_pkg,
// csc_cordic_stage). out_valid rises once a request has passed the magnitude, 2*pi, pi,
// fold, CORDIC iteration, sign and output registers. Throughput: one request per cycle
// while busy is low, one CORDIC iteration per pipeline stage; the pipeline never stalls.
// Reset (synchronous, rst_n low) clears the valid bits; busy is set during reset and
// cleared at the first clock edge with rst_n high. Data registers are not reset.
module cordic_sine_cosine_unit
  import csc_pkg::*;
#(
  parameter int ITERATIONS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ANGLE_W-1:0] in_angle,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_sine_value,
  output logic signed [OUT_W-1:0] out_cosine_value
);

  localparam int NUM_ITER = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
  localparam int LAT      = NUM_ITER + 5;

  logic busy_r;

  // Stage 0: magnitude, Q3.28 -> Q2.30
  csc_ctl_t       ctl0_r;
  logic [A_W-1:0] a0_r;
  logic [ANGLE_W:0] mag_ext;

  // Stage 1: 2*pi reduction
  csc_ctl_t       ctl1_r;
  logic [A_W-1:0] a1_r, a1_nxt;

  // Stage 2: pi reduction
  csc_ctl_t       ctl2_r, ctl2_nxt;
  logic [A_W-1:0] a2_r, a2_nxt;

  // Stage 3: quadrant fold and CORDIC start vector
  csc_ctl_t ctl3_nxt;
  z_t       z3_nxt;

  // CORDIC pipeline taps
  csc_ctl_t ctl_p [NUM_ITER+1];
  xy_t      x_p   [NUM_ITER+1];
  xy_t      y_p   [NUM_ITER+1];
  z_t       z_p   [NUM_ITER+1];

  // Sign stage and output stage
  logic                  vn_r;
  logic signed [XY_W:0]  sn_r, cn_r, sn_nxt, cn_nxt;
  logic signed [XY_W:0]  s_sel, c_sel;
  logic                  out_valid_r;
  logic signed [OUT_W-1:0] sine_r, cosine_r, sine_nxt, cosine_nxt;

  // busy only while the pipeline comes out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  // Stage 0
  assign mag_ext = in_angle[ANGLE_W-1] ? -{in_angle[ANGLE_W-1], in_angle}
                                       : {in_angle[ANGLE_W-1], in_angle};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r.valid <= start & ~busy_r;
      ctl0_r.neg   <= in_angle[ANGLE_W-1];
      ctl0_r.flip  <= 1'b0;
      ctl0_r.swap  <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    a0_r <= {mag_ext[ANGLE_W-1:0], 2'b00};
  end

  // Stage 1: at most one 2*pi fits in an 8 rad magnitude
  assign a1_nxt = (a0_r > TWO_PI_Q30) ? a0_r - TWO_PI_Q30 : a0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl0_r;
    end
  end
  always_ff @(posedge clk) begin
    a1_r <= a1_nxt;
  end

  // Stage 2: at most one pi remains; removing it flips both signs
  always_comb begin
    ctl2_nxt = ctl1_r;
    a2_nxt   = a1_r;
    if (a1_r > PI_Q30) begin
      a2_nxt        = a1_r - PI_Q30;
      ctl2_nxt.flip = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl2_nxt;
    end
  end
  always_ff @(posedge clk) begin
    a2_r <= a2_nxt;
  end

  // Stage 3: fold second quadrant into the first
  always_comb begin
    ctl3_nxt = ctl2_r;
    z3_nxt   = z_t'(a2_r[Z_W-1:0]);
    if (a2_r > HALF_PI_Q30) begin
      z3_nxt        = z_t'(a2_r[Z_W-1:0] - HALF_PI_Q30[Z_W-1:0]);
      ctl3_nxt.swap = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p[0] <= '0;
    end else begin
      ctl_p[0] <= ctl3_nxt;
    end
  end
  always_ff @(posedge clk) begin
    x_p[0] <= GAIN_K_Q30;
    y_p[0] <= '0;
    z_p[0] <= z3_nxt;
  end

  // Unrolled CORDIC iterations, one register stage each
  for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
    csc_cordic_stage #(
      .SHIFT (k)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_p[k]),
      .x_i   (x_p[k]),
      .y_i   (y_p[k]),
      .z_i   (z_p[k]),
      .ctl_o (ctl_p[k+1]),
      .x_o   (x_p[k+1]),
      .y_o   (y_p[k+1]),
      .z_o   (z_p[k+1])
    );
  end

  // Sign stage: pick sine/cosine, apply quadrant and input signs
  always_comb begin
    s_sel = ctl_p[NUM_ITER].swap ? {x_p[NUM_ITER][XY_W-1], x_p[NUM_ITER]}
                                 : {y_p[NUM_ITER][XY_W-1], y_p[NUM_ITER]};
    c_sel = ctl_p[NUM_ITER].swap ? {y_p[NUM_ITER][XY_W-1], y_p[NUM_ITER]}
                                 : {x_p[NUM_ITER][XY_W-1], x_p[NUM_ITER]};
    sn_nxt = (ctl_p[NUM_ITER].flip ^ ctl_p[NUM_ITER].neg) ? -s_sel : s_sel;
    cn_nxt = (ctl_p[NUM_ITER].flip ^ ctl_p[NUM_ITER].swap) ? -c_sel : c_sel;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else begin
      vn_r <= ctl_p[NUM_ITER].valid;
    end
  end
  always_ff @(posedge clk) begin
    sn_r <= sn_nxt;
    cn_r <= cn_nxt;
  end

  // Output stage: clamp to +-1.0
  always_comb begin
    priority if (sn_r > SAT_POS) begin
      sine_nxt = SAT_POS[OUT_W-1:0];
    end else if (sn_r < SAT_NEG) begin
      sine_nxt = SAT_NEG[OUT_W-1:0];
    end else begin
      sine_nxt = sn_r[OUT_W-1:0];
    end
    priority if (cn_r > SAT_POS) begin
      cosine_nxt = SAT_POS[OUT_W-1:0];
    end else if (cn_r < SAT_NEG) begin
      cosine_nxt = SAT_NEG[OUT_W-1:0];
    end else begin
      cosine_nxt = cn_r[OUT_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vn_r;
    end
  end
  always_ff @(posedge clk) begin
    sine_r   <= sine_nxt;
    cosine_r <= cosine_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sine_value   = sine_r;
  assign out_cosine_value = cosine_r;

`ifndef SYNTH
  // Every result strobe traces back to an earlier request taken while busy was low
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT + 1))
    else $error("result strobe without matching request");

  // Reduced angle never exceeds pi
  a_pi_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl2_r.valid |-> (a2_r <= PI_Q30))
    else $error("angle above pi after reduction");

  // CORDIC start angle lies in the first quadrant
  a_quadrant: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_p[0].valid |-> (!z_p[0][Z_W-1] && (A_W'(z_p[0]) <= HALF_PI_Q30)))
    else $error("CORDIC start angle outside first quadrant");

  // Results stay inside the clamp range
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_sine_value <= 32'sh4000_0000)
                && (out_sine_value >= -32'sh4000_0000)
                && (out_cosine_value <= 32'sh4000_0000)
                && (out_cosine_value >= -32'sh4000_0000)))
    else $error("result outside +-1.0");
`endif

endmodule
